// ===== design/ofip_pkg.sv =====
// Shared types, constants and helper function for the face index parser
`timescale 1ns / 1ps

package ofip_pkg;

  // longest first token of a line before it counts as an error
  localparam int MAX_KEYWORD_BYTES = 8;
  localparam int KW_LEN_W          = $clog2(MAX_KEYWORD_BYTES + 1);

  // character codes
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_V     = 8'h76;

  // field select codes within a corner group
  localparam logic [1:0] FIELD_POS  = 2'd0;
  localparam logic [1:0] FIELD_TEX  = 2'd1;
  localparam logic [1:0] FIELD_NORM = 2'd2;

  // line phase, one-hot
  typedef enum logic [6:0] {
    PH_START  = 7'b0000001,
    PH_KEY    = 7'b0000010,
    PH_SKIP   = 7'b0000100,
    PH_GAP    = 7'b0001000,
    PH_FSTART = 7'b0010000,
    PH_FBODY  = 7'b0100000,
    PH_HALT   = 7'b1000000
  } phase_t;

  // one result item
  typedef struct packed {
    logic               corner_valid;
    logic               face_end;
    logic signed [7:0]  corner_count;
    logic signed [31:0] vert_index;
    logic signed [31:0] texc_index;
    logic signed [31:0] norm_index;
    logic               parse_error;
  } result_t;

  // negative index is relative to the running count, otherwise one-based
  function automatic logic [31:0] fix_index(input logic [31:0] v, input logic [31:0] count);
    logic [31:0] r;
    r = v[31] ? (v + count) : (v - 32'd1);
    return r;
  endfunction

endpackage

// ===== design/ofip_in_stage.sv =====
// Input byte register with stall towards the byte source
`timescale 1ns / 1ps

module ofip_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_stall,
  input  logic [7:0] text_byte,
  input  logic       advance,
  output logic       byte_full,
  output logic [7:0] byte_q
);

  logic accept;

  // hold off the source only while a byte waits and the result side is blocked
  assign text_stall = byte_full && !advance;
  assign accept     = text_valid && !text_stall;

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_full <= 1'b0;
    end else begin
      byte_full <= accept || (byte_full && !advance);
    end
  end

  // byte register, loaded on each transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_q <= text_byte;
    end
  end

endmodule

// ===== design/ofip_parse.sv =====
// Line classifier, face group decoder and index fixup
`timescale 1ns / 1ps

module ofip_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        b,
  output logic              produce,
  output ofip_pkg::result_t res
);

  ofip_pkg::phase_t              phase, phase_next;
  logic [7:0]                    kw0, kw0_next;
  logic [7:0]                    kw1, kw1_next;
  logic [ofip_pkg::KW_LEN_W-1:0] kw_len, kw_len_next;
  logic [1:0]                    sel, sel_next;
  logic                          neg, neg_next;
  logic [31:0]                   pos_acc, pos_acc_next;
  logic [31:0]                   tex_acc, tex_acc_next;
  logic [31:0]                   norm_acc, norm_acc_next;
  logic                          in_group, in_group_next;
  logic [31:0]                   pos_cnt, pos_cnt_next;
  logic [31:0]                   tex_cnt, tex_cnt_next;
  logic [31:0]                   norm_cnt, norm_cnt_next;
  logic [7:0]                    corners, corners_next;

  logic        nl, blank, digit, minus, slash, hash;
  logic [31:0] d;
  logic [31:0] cur_acc, scaled, acc_new;
  logic [31:0] pos_fix, tex_fix, norm_fix;
  logic        is_v, is_vt, is_vn, is_f;
  ofip_pkg::result_t corner_res;

  // byte classes
  assign nl    = (b == ofip_pkg::CH_NL);
  assign blank = (b == ofip_pkg::CH_SPACE) || (b == ofip_pkg::CH_TAB) || (b == ofip_pkg::CH_CR);
  assign digit = (b >= ofip_pkg::CH_ZERO) && (b <= ofip_pkg::CH_NINE);
  assign minus = (b == ofip_pkg::CH_MINUS);
  assign slash = (b == ofip_pkg::CH_SLASH);
  assign hash  = (b == ofip_pkg::CH_HASH);
  assign d     = {28'd0, b[3:0]};

  // decimal accumulate on the selected field: acc * 10 +/- digit
  always_comb begin
    case (sel)
      ofip_pkg::FIELD_POS: cur_acc = pos_acc;
      ofip_pkg::FIELD_TEX: cur_acc = tex_acc;
      default:             cur_acc = norm_acc;
    endcase
  end
  assign scaled  = (cur_acc << 3) + (cur_acc << 1);
  assign acc_new = neg ? (scaled - d) : (scaled + d);

  // fixed-up indices of the held corner
  assign pos_fix  = ofip_pkg::fix_index(pos_acc, pos_cnt);
  assign tex_fix  = ofip_pkg::fix_index(tex_acc, tex_cnt);
  assign norm_fix = ofip_pkg::fix_index(norm_acc, norm_cnt);

  // keyword match
  assign is_v  = (kw_len == ofip_pkg::KW_LEN_W'(1)) && (kw0 == ofip_pkg::CH_V);
  assign is_vt = (kw_len == ofip_pkg::KW_LEN_W'(2)) && (kw0 == ofip_pkg::CH_V)
              && (kw1 == ofip_pkg::CH_T);
  assign is_vn = (kw_len == ofip_pkg::KW_LEN_W'(2)) && (kw0 == ofip_pkg::CH_V)
              && (kw1 == ofip_pkg::CH_N);
  assign is_f  = (kw_len == ofip_pkg::KW_LEN_W'(1)) && (kw0 == ofip_pkg::CH_F);

  // corner result template, count and end filled in where used
  always_comb begin
    corner_res              = '0;
    corner_res.corner_valid = 1'b1;
    corner_res.vert_index   = pos_fix;
    corner_res.texc_index   = tex_fix;
    corner_res.norm_index   = norm_fix;
  end

  // next state and result for the byte in the input register
  always_comb begin
    phase_next    = phase;
    kw0_next      = kw0;
    kw1_next      = kw1;
    kw_len_next   = kw_len;
    sel_next      = sel;
    neg_next      = neg;
    pos_acc_next  = pos_acc;
    tex_acc_next  = tex_acc;
    norm_acc_next = norm_acc;
    in_group_next = in_group;
    pos_cnt_next  = pos_cnt;
    tex_cnt_next  = tex_cnt;
    norm_cnt_next = norm_cnt;
    corners_next  = corners;
    produce       = 1'b0;
    res           = '0;
    if (fire) begin
      case (phase)
        ofip_pkg::PH_START: begin
          if (!nl && !blank) begin
            if (hash) begin
              phase_next = ofip_pkg::PH_SKIP;
            end else begin
              kw0_next    = b;
              kw_len_next = ofip_pkg::KW_LEN_W'(1);
              phase_next  = ofip_pkg::PH_KEY;
            end
          end
        end
        ofip_pkg::PH_KEY: begin
          if (!nl && !blank) begin
            if (kw_len >= ofip_pkg::KW_LEN_W'(ofip_pkg::MAX_KEYWORD_BYTES)) begin
              phase_next      = ofip_pkg::PH_HALT;
              in_group_next   = 1'b0;
              produce         = 1'b1;
              res.parse_error = 1'b1;
            end else begin
              if (kw_len == ofip_pkg::KW_LEN_W'(1)) begin
                kw1_next = b;
              end
              kw_len_next = kw_len + ofip_pkg::KW_LEN_W'(1);
            end
          end else if (is_f) begin
            corners_next  = 8'd0;
            in_group_next = 1'b0;
            if (nl) begin
              phase_next   = ofip_pkg::PH_START;
              produce      = 1'b1;
              res.face_end = 1'b1;
            end else begin
              phase_next = ofip_pkg::PH_GAP;
            end
          end else begin
            if (is_v) begin
              pos_cnt_next = pos_cnt + 32'd1;
            end
            if (is_vt) begin
              tex_cnt_next = tex_cnt + 32'd1;
            end
            if (is_vn) begin
              norm_cnt_next = norm_cnt + 32'd1;
            end
            phase_next = nl ? ofip_pkg::PH_START : ofip_pkg::PH_SKIP;
          end
        end
        ofip_pkg::PH_SKIP: begin
          if (nl) begin
            phase_next = ofip_pkg::PH_START;
          end
        end
        ofip_pkg::PH_GAP: begin
          if (nl) begin
            produce = 1'b1;
            if (in_group) begin
              res = corner_res;
            end
            res.face_end     = 1'b1;
            res.corner_count = corners;
            in_group_next    = 1'b0;
            phase_next       = ofip_pkg::PH_START;
          end else if (blank) begin
            phase_next = phase;
          end else if (digit || minus || slash) begin
            // a new group releases the held corner as a non-final one
            if (in_group) begin
              produce = 1'b1;
              res     = corner_res;
            end
            sel_next      = ofip_pkg::FIELD_POS;
            neg_next      = 1'b0;
            pos_acc_next  = digit ? d : 32'd0;
            tex_acc_next  = 32'd0;
            norm_acc_next = 32'd0;
            in_group_next = 1'b1;
            if (digit) begin
              phase_next = ofip_pkg::PH_FBODY;
            end else if (minus) begin
              neg_next   = 1'b1;
              phase_next = ofip_pkg::PH_FBODY;
            end else begin
              sel_next   = ofip_pkg::FIELD_TEX;
              phase_next = ofip_pkg::PH_FSTART;
            end
          end else begin
            phase_next      = ofip_pkg::PH_HALT;
            in_group_next   = 1'b0;
            produce         = 1'b1;
            res.parse_error = 1'b1;
          end
        end
        ofip_pkg::PH_FSTART, ofip_pkg::PH_FBODY: begin
          if (blank) begin
            corners_next = corners + 8'd1;
            phase_next   = ofip_pkg::PH_GAP;
          end else if (nl) begin
            corners_next     = corners + 8'd1;
            produce          = 1'b1;
            res              = corner_res;
            res.face_end     = 1'b1;
            res.corner_count = corners + 8'd1;
            in_group_next    = 1'b0;
            phase_next       = ofip_pkg::PH_START;
          end else if (digit) begin
            case (sel)
              ofip_pkg::FIELD_POS: pos_acc_next = acc_new;
              ofip_pkg::FIELD_TEX: tex_acc_next = acc_new;
              default:             norm_acc_next = acc_new;
            endcase
            phase_next = ofip_pkg::PH_FBODY;
          end else if (minus && (phase == ofip_pkg::PH_FSTART)) begin
            neg_next   = 1'b1;
            phase_next = ofip_pkg::PH_FBODY;
          end else if (slash && (sel != ofip_pkg::FIELD_NORM)) begin
            sel_next   = sel + 2'd1;
            neg_next   = 1'b0;
            phase_next = ofip_pkg::PH_FSTART;
          end else begin
            phase_next      = ofip_pkg::PH_HALT;
            in_group_next   = 1'b0;
            produce         = 1'b1;
            res.parse_error = 1'b1;
          end
        end
        ofip_pkg::PH_HALT: begin
          phase_next = ofip_pkg::PH_HALT;
        end
        default: begin
          phase_next = ofip_pkg::PH_HALT;
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= ofip_pkg::PH_START;
      kw0      <= 8'd0;
      kw1      <= 8'd0;
      kw_len   <= '0;
      sel      <= ofip_pkg::FIELD_POS;
      neg      <= 1'b0;
      pos_acc  <= 32'd0;
      tex_acc  <= 32'd0;
      norm_acc <= 32'd0;
      in_group <= 1'b0;
      pos_cnt  <= 32'd0;
      tex_cnt  <= 32'd0;
      norm_cnt <= 32'd0;
      corners  <= 8'd0;
    end else begin
      phase    <= phase_next;
      kw0      <= kw0_next;
      kw1      <= kw1_next;
      kw_len   <= kw_len_next;
      sel      <= sel_next;
      neg      <= neg_next;
      pos_acc  <= pos_acc_next;
      tex_acc  <= tex_acc_next;
      norm_acc <= norm_acc_next;
      in_group <= in_group_next;
      pos_cnt  <= pos_cnt_next;
      tex_cnt  <= tex_cnt_next;
      norm_cnt <= norm_cnt_next;
      corners  <= corners_next;
    end
  end

endmodule

// ===== design/ofip_out_stage.sv =====
// Result register towards the consumer
`timescale 1ns / 1ps

module ofip_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              produce,
  input  ofip_pkg::result_t res,
  input  logic              result_stall,
  output logic              advance,
  output logic              result_valid,
  output ofip_pkg::result_t res_q
);

  // register is free when empty or its result leaves this cycle
  assign advance = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= produce;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      res_q <= res;
    end
  end

endmodule

// ===== design/obj_face_index_parser_core.sv =====
// A transferred byte is held in the input register; its result, if any, is registered in the result register
// Throughput: one byte per cycle while the result side is not stalled; the input register and the result register
// each hold one item, so a stalled result blocks input only once both are full
// Reset: synchronous, active high; clears line state, counters and both registers
// After a parse error no further results appear until reset
`timescale 1ns / 1ps

module obj_face_index_parser_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               text_valid,
  output logic               text_stall,
  input  logic [7:0]         text_byte,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               corner_valid,
  output logic               face_end,
  output logic signed [7:0]  corner_count,
  output logic signed [31:0] vert_index,
  output logic signed [31:0] texc_index,
  output logic signed [31:0] norm_index,
  output logic               parse_error
);

  logic              advance;
  logic              byte_full;
  logic [7:0]        byte_q;
  logic              produce;
  ofip_pkg::result_t res;
  ofip_pkg::result_t res_q;

  // input register
  ofip_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text_byte  (text_byte),
    .advance    (advance),
    .byte_full  (byte_full),
    .byte_q     (byte_q)
  );

  // parser, steps once per held byte while the result register is free
  ofip_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .fire    (byte_full && advance),
    .b       (byte_q),
    .produce (produce),
    .res     (res)
  );

  // result register
  ofip_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .produce      (produce),
    .res          (res),
    .result_stall (result_stall),
    .advance      (advance),
    .result_valid (result_valid),
    .res_q        (res_q)
  );

  assign corner_valid = res_q.corner_valid;
  assign face_end     = res_q.face_end;
  assign corner_count = res_q.corner_count;
  assign vert_index   = res_q.vert_index;
  assign texc_index   = res_q.texc_index;
  assign norm_index   = res_q.norm_index;
  assign parse_error  = res_q.parse_error;

endmodule

// ===== design/ofip_checker.sv =====
// Port-level checks for the face index parser, bound to the top level
`timescale 1ns / 1ps

module ofip_checker (
  input logic               clk,
  input logic               rst,
  input logic               text_valid,
  input logic               text_stall,
  input logic [7:0]         text_byte,
  input logic               result_valid,
  input logic               result_stall,
  input logic               corner_valid,
  input logic               face_end,
  input logic signed [7:0]  corner_count,
  input logic signed [31:0] vert_index,
  input logic signed [31:0] texc_index,
  input logic signed [31:0] norm_index,
  input logic               parse_error
);

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(vert_index)
      && $stable(texc_index) && $stable(norm_index) && $stable(face_end))
    else $error("stalled result changed");

  // a result with no corner carries zero indices
  a_no_corner: assert property (@(posedge clk) disable iff (rst)
    result_valid && !corner_valid |-> vert_index == 0 && texc_index == 0 && norm_index == 0)
    else $error("indices set without a corner");

  // corner count only travels with a face end
  a_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && !face_end |-> corner_count == 0)
    else $error("corner count without face end");

  // an error result stands alone and is the last one
  a_err_alone: assert property (@(posedge clk) disable iff (rst)
    result_valid && parse_error |-> !corner_valid && !face_end)
    else $error("error result carries other fields");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && parse_error && !result_stall |=> !result_valid)
    else $error("result after parse error");

endmodule

bind obj_face_index_parser_core ofip_checker u_ofip_checker (.*);
